// ===== hw/rtl/mpq_pkg.sv =====
// Shared types and constants for the max priority queue.
package mpq_pkg;

	localparam int DATA_W       = 32;
	localparam int OCC_W        = 5;
	localparam int DEF_CAPACITY = 16;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	typedef struct packed {
		req_t                      req_type;
		logic signed [DATA_W-1:0]  value;
	} mpq_req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  removed_value;
		logic [OCC_W-1:0]          occupancy;
	} mpq_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mpq_ctl_t;

endpackage

// ===== hw/rtl/mpq_engine.sv =====
// Storage and scan/compact sequencer of the max priority queue.
module mpq_engine #(
	parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mpq_pkg::mpq_req_t req,
	input  logic              take,
	output mpq_pkg::mpq_ctl_t ctl,
	output mpq_pkg::mpq_res_t res
);
	import mpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            rd_idx_q;
	logic                     first_q;
	logic [AW-1:0]            best_idx_q;
	logic signed [DATA_W-1:0] best_val_q;
	mpq_res_t                 res_q;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rdata_s1;
	logic [AW-1:0]            ridx_s1;
	logic                     rvalid_s1;

	logic                     issue;
	logic                     upd;
	logic [AW-1:0]            fin_idx;
	logic signed [DATA_W-1:0] fin_val;
	logic                     scan_end;
	logic                     full;
	logic                     we;
	logic [AW-1:0]            wa;
	logic signed [DATA_W-1:0] wd;

	// Issue one read a cycle while scanning or compacting
	assign issue = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_idx_q < cnt_q);

	// Compare unit: strict greater keeps the earliest of equal maxima
	assign upd     = rvalid_s1 && (first_q || (rdata_s1 > best_val_q));
	assign fin_idx = upd ? ridx_s1 : best_idx_q;
	assign fin_val = upd ? rdata_s1 : best_val_q;
	assign scan_end = rvalid_s1 && (CW'(ridx_s1) == (cnt_q - CW'(1)));

	assign full = (cnt_q == CW'(CAPACITY));

	// Write port: append on enqueue, move one word down while compacting
	always_comb begin
		we = 1'b0;
		wa = ridx_s1 - AW'(1);
		wd = rdata_s1;
		if (state_q == S_IDLE && start && req.req_type == REQ_ENQ && !full) begin
			we = 1'b1;
			wa = cnt_q[AW-1:0];
			wd = req.value;
		end else if (state_q == S_SHIFT && rvalid_s1) begin
			we = 1'b1;
		end
	end

	// Memory with registered read
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_idx_q[AW-1:0]];
		ridx_s1  <= rd_idx_q[AW-1:0];
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			rvalid_s1  <= 1'b0;
			first_q    <= 1'b0;
			best_idx_q <= '0;
			best_val_q <= '0;
			res_q      <= '0;
		end else begin
			rvalid_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q.removed_value <= '0;
						state_q             <= S_DONE;
						if (req.req_type == REQ_ENQ) begin
							if (full) begin
								res_q.status    <= ST_FULL;
								res_q.occupancy <= OCC_W'(cnt_q);
							end else begin
								res_q.status    <= ST_OK;
								res_q.occupancy <= OCC_W'(cnt_q + CW'(1));
								cnt_q           <= cnt_q + CW'(1);
							end
						end else if (cnt_q == '0) begin
							res_q.status    <= ST_EMPTY;
							res_q.occupancy <= '0;
						end else begin
							rd_idx_q <= '0;
							first_q  <= 1'b1;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rvalid_s1) begin
						first_q    <= 1'b0;
						best_idx_q <= fin_idx;
						best_val_q <= fin_val;
					end
					if (scan_end) begin
						rd_idx_q <= CW'(fin_idx) + CW'(1);
						state_q  <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// Last move, if any, is written on this same edge
					if (rd_idx_q >= cnt_q) begin
						cnt_q               <= cnt_q - CW'(1);
						res_q.status        <= ST_OK;
						res_q.removed_value <= best_val_q;
						res_q.occupancy     <= OCC_W'(cnt_q - CW'(1));
						state_q             <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ctl.busy = (state_q != S_IDLE);
	assign ctl.done = (state_q == S_DONE);
	assign res      = res_q;

	// Count stays within the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// A new request only arrives while idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("request started while busy");

	// A finished word holds until taken
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !take) |=> (state_q == S_DONE && $stable(res_q)))
		else $error("result changed before it was taken");

	// Compaction never writes below the removed slot or at slot zero from a read of zero
	a_move_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && rvalid_s1) |-> (ridx_s1 > best_idx_q))
		else $error("compaction move out of range");

endmodule

// ===== hw/rtl/max_priority_queue.sv =====
// Top level of the bounded max priority queue of signed 32-bit words.
//
// Input channel (in_valid / in_stall) carries one request word: req_type 0
// appends value, req_type 1 removes the greatest stored value (earliest of
// equal maxima first). Output channel (out_valid / out_stall) returns one
// word per request: status, removed_value and occupancy after the request.
// The block handles one request at a time; in_stall is high from accept
// until the result has moved into the output register.
// Enqueue and the empty/full cases: the result is registered as the
// sequencer goes straight to its done state. Dequeue with n stored words:
// one read a cycle through the single read port for the scan of all n
// words, then one word moved a cycle to close the gap above the removed
// slot; the result then moves from the done state to the output register.
// A stalled output holds its word; the next result waits in the sequencer
// and the input stays stalled. Reset empties the queue at once.
module max_priority_queue #(
	parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic signed [mpq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [mpq_pkg::DATA_W-1:0] removed_value,
	output logic [mpq_pkg::OCC_W-1:0]         occupancy
);
	import mpq_pkg::*;

	mpq_req_t req;
	mpq_ctl_t ctl;
	mpq_res_t res;
	logic     start;
	logic     take;
	logic     out_valid_q;
	mpq_res_t out_q;

	assign req.req_type = req_t'(req_type);
	assign req.value    = value;
	assign in_stall     = ctl.busy;
	assign start        = in_valid && !ctl.busy;
	assign take         = ctl.done && (!out_valid_q || !out_stall);

	mpq_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.take  (take),
		.ctl   (ctl),
		.res   (res)
	);

	// Advance or drop the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign removed_value = out_q.removed_value;
	assign occupancy     = out_q.occupancy;

endmodule
